@@ hw/rtl/qrs_pkg.sv @@
// Shared types and constants for the quadratic root solver.
// No dependencies.
package qrs_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        KIND_TWO_REAL = 2'd0,
        KIND_DOUBLE   = 2'd1,
        KIND_COMPLEX  = 2'd2,
        KIND_A_ZERO   = 2'd3
    } root_kind_t;

    // Sideband carried with each word along the pipeline
    typedef struct packed {
        logic       a_neg;
        root_kind_t kind;
    } qrs_side_t;

endpackage

@@ hw/rtl/quadratic_root_solver.sv @@
// Top level of the quadratic root solver: discriminant, square root, dividers.
// Depends on qrs_pkg, qrs_disc, qrs_sqrt, qrs_div.
//
// Fully pipelined: one coefficient set is accepted every cycle while the
// output is not stalled. A set passes through the discriminant stages, the
// square root (one root bit per stage over a 2*DATA_WIDTH+4 bit radicand),
// the numerator setup register and the division (one quotient bit per
// stage), then the output register.
// The whole pipeline advances when the output register is empty or taken,
// so s_ready follows m_ready combinationally through that register.
module quadratic_root_solver
    import qrs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [DATA_WIDTH-1:0] s_coef_a,
    input  logic [DATA_WIDTH-1:0] s_coef_b,
    input  logic [DATA_WIDTH-1:0] s_coef_c,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_root_kind,
    output logic [DATA_WIDTH-1:0] m_first_value,
    output logic [DATA_WIDTH-1:0] m_second_value,
    output logic                  m_saturated
);
    localparam int W   = DATA_WIDTH;
    localparam int DW  = 2 * W + 4;       // radicand width (even)
    localparam int RW  = DW / 2;
    localparam int NW  = W + 2;           // signed numerator width
    localparam int QW  = NW - 1 + FRAC_BITS;
    localparam int SW  = $bits(qrs_side_t);

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Discriminant
    logic            d_valid, d_dneg, d_aneg;
    logic [DW-2:0]   d_dmag;
    logic [W-1:0]    d_amag;
    logic [W:0]      d_negb;
    qrs_disc #(.DATA_WIDTH(W)) u_disc (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(s_valid && s_ready),
        .coef_a(s_coef_a), .coef_b(s_coef_b), .coef_c(s_coef_c),
        .out_valid(d_valid), .out_dmag(d_dmag), .out_dneg(d_dneg),
        .out_amag(d_amag), .out_aneg(d_aneg), .out_negb(d_negb)
    );

    // Carry kind, a and -b past the root
    localparam int CW = SW + W + (W + 1);
    qrs_side_t      d_side;
    always_comb begin
        d_side.a_neg = d_aneg;
        if (d_amag == '0) begin
            d_side.kind = KIND_A_ZERO;
        end else if (d_dneg) begin
            d_side.kind = KIND_COMPLEX;
        end else if (d_dmag == '0) begin
            d_side.kind = KIND_DOUBLE;
        end else begin
            d_side.kind = KIND_TWO_REAL;
        end
    end

    logic          r_valid;
    logic [RW-1:0] r_root;
    logic [CW-1:0] r_carry;
    qrs_sqrt #(.IN_W(DW), .SIDE_W(CW)) u_sqrt (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(d_valid), .in_rad({1'b0, d_dmag}),
        .in_side({d_side, d_amag, d_negb}),
        .out_valid(r_valid), .out_root(r_root), .out_side(r_carry)
    );

    qrs_side_t    r_side;
    logic [W-1:0] r_amag;
    logic [W:0]   r_negb;
    assign {r_side, r_amag, r_negb} = r_carry;

    // Numerators: root is below 2^(W+1), so every sum fits NW signed bits
    logic [NW-1:0] s_ext, nb_ext, n1, n2;
    always_comb begin
        s_ext  = NW'(r_root);
        nb_ext = {r_negb[W], r_negb};
        unique case (r_side.kind)
            KIND_COMPLEX: begin
                n1 = nb_ext;
                n2 = s_ext;
            end
            KIND_TWO_REAL: begin
                n1 = nb_ext + s_ext;
                n2 = nb_ext - s_ext;
            end
            default: begin
                n1 = nb_ext;
                n2 = '0;
            end
        endcase
    end

    logic          n_valid_reg;
    logic [QW-1:0] n1m_reg, n2m_reg;
    logic          n1neg_reg, n2neg_reg;
    logic [W:0]    den_reg;
    qrs_side_t     n_side_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_valid_reg <= 1'b0;
        end else if (en) begin
            n_valid_reg <= r_valid;
        end
        if (en) begin
            n1m_reg    <= QW'(n1[NW-1] ? NW'(0) - n1 : n1) << FRAC_BITS;
            n2m_reg    <= QW'(n2[NW-1] ? NW'(0) - n2 : n2) << FRAC_BITS;
            n1neg_reg  <= n1[NW-1] != r_side.a_neg;
            n2neg_reg  <= n2[NW-1] != r_side.a_neg;
            den_reg    <= {r_amag, 1'b0};
            n_side_reg <= r_side;
        end
    end

    // Two dividers in lockstep
    logic          q1_valid, q1_sat, q2_sat;
    logic [W-1:0]  q1, q2;
    logic [SW-1:0] q1_side, q2_side_unused;
    logic          q2_valid;
    qrs_div #(.NUM_W(QW), .DEN_W(W + 1), .OUT_W(W), .SIDE_W(SW)) u_div1 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(n_valid_reg), .in_num(n1m_reg), .in_den(den_reg),
        .in_neg(n1neg_reg), .in_side(n_side_reg),
        .out_valid(q1_valid), .out_quot(q1), .out_sat(q1_sat), .out_side(q1_side)
    );
    qrs_div #(.NUM_W(QW), .DEN_W(W + 1), .OUT_W(W), .SIDE_W(SW)) u_div2 (
        .aclk(aclk), .aresetn(aresetn), .en(en),
        .in_valid(n_valid_reg), .in_num(n2m_reg), .in_den(den_reg),
        .in_neg(n2neg_reg), .in_side(n_side_reg),
        .out_valid(q2_valid), .out_quot(q2), .out_sat(q2_sat), .out_side(q2_side_unused)
    );

    // Output register
    qrs_side_t o_side;
    assign o_side = q1_side;
    logic          m_valid_reg;
    logic [1:0]    kind_reg;
    logic [W-1:0]  first_reg, second_reg;
    logic          sat_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= q1_valid && q2_valid;
        end
        if (en) begin
            kind_reg <= o_side.kind;
            if (o_side.kind == KIND_A_ZERO) begin
                first_reg  <= '0;
                second_reg <= '0;
                sat_reg    <= 1'b0;
            end else if (o_side.kind == KIND_DOUBLE) begin
                first_reg  <= q1;
                second_reg <= '0;
                sat_reg    <= q1_sat;
            end else begin
                first_reg  <= q1;
                second_reg <= q2;
                sat_reg    <= q1_sat || q2_sat || (q2_side_unused != q1_side);
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_root_kind    = kind_reg;
    assign m_first_value  = first_reg;
    assign m_second_value = second_reg;
    assign m_saturated    = sat_reg;
endmodule

@@ hw/rtl/qrs_sqrt.sv @@
// Pipelined floor integer square root, one result bit per stage.
// Depends on qrs_pkg.
module qrs_sqrt
    import qrs_pkg::*;
#(
    parameter int IN_W  = 128,
    parameter int SIDE_W = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_valid,
    input  logic [IN_W-1:0]     in_rad,
    input  logic [SIDE_W-1:0]   in_side,
    output logic                out_valid,
    output logic [IN_W/2-1:0]   out_root,
    output logic [SIDE_W-1:0]   out_side
);
    localparam int RW = IN_W / 2;

    logic [IN_W-1:0]   rem_reg  [RW+1];
    logic [RW-1:0]     root_reg [RW+1];
    logic [SIDE_W-1:0] side_reg [RW+1];
    logic              vld_reg  [RW+1];

    always_comb begin
        rem_reg[0]  = in_rad;
        root_reg[0] = '0;
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    // Advance one root bit per stage (restoring, non-performing method)
    for (genvar g = 0; g < RW; g++) begin : g_stage
        localparam int BIT = RW - 1 - g;
        logic [IN_W+1:0] trial;
        logic [IN_W+1:0] rem_next;
        logic [RW-1:0]   root_next;
        always_comb begin
            trial = ({2'b00, {(IN_W-RW){1'b0}}, root_reg[g]} << (BIT + 1))
                  + ({{(IN_W+1){1'b0}}, 1'b1} << (2 * BIT));
            if ({2'b00, rem_reg[g]} >= trial) begin
                rem_next  = {2'b00, rem_reg[g]} - trial;
                root_next = root_reg[g] | (RW'(1) << BIT);
            end else begin
                rem_next  = {2'b00, rem_reg[g]};
                root_next = root_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
            if (en) begin
                rem_reg[g+1]  <= rem_next[IN_W-1:0];
                root_reg[g+1] <= root_next;
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    assign out_valid = vld_reg[RW];
    assign out_root  = root_reg[RW];
    assign out_side  = side_reg[RW];
endmodule

@@ hw/rtl/qrs_div.sv @@
// Pipelined restoring divider with signed saturation to OUT_W bits.
// Depends on qrs_pkg.
module qrs_div
    import qrs_pkg::*;
#(
    parameter int NUM_W  = 64,
    parameter int DEN_W  = 33,
    parameter int OUT_W  = 32,
    parameter int SIDE_W = 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  logic [NUM_W-1:0]   in_num,
    input  logic [DEN_W-1:0]   in_den,
    input  logic               in_neg,
    input  logic [SIDE_W-1:0]  in_side,
    output logic               out_valid,
    output logic [OUT_W-1:0]   out_quot,
    output logic               out_sat,
    output logic [SIDE_W-1:0]  out_side
);
    logic [DEN_W-1:0]  rem_reg  [NUM_W+1];
    logic [NUM_W-1:0]  q_reg    [NUM_W+1];
    logic [DEN_W-1:0]  den_reg  [NUM_W+1];
    logic              neg_reg  [NUM_W+1];
    logic [SIDE_W-1:0] side_reg [NUM_W+1];
    logic              vld_reg  [NUM_W+1];

    always_comb begin
        rem_reg[0]  = '0;
        q_reg[0]    = in_num;
        den_reg[0]  = in_den;
        neg_reg[0]  = in_neg;
        side_reg[0] = in_side;
        vld_reg[0]  = in_valid;
    end

    // Shift one numerator bit into the remainder per stage
    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [DEN_W:0]   sh;
        logic [DEN_W-1:0] rem_next;
        logic             qb;
        always_comb begin
            sh = {rem_reg[g], q_reg[g][NUM_W-1]};
            qb = (sh >= {1'b0, den_reg[g]});
            if (qb) begin
                rem_next = DEN_W'(sh - {1'b0, den_reg[g]});
            end else begin
                rem_next = sh[DEN_W-1:0];
            end
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[g+1] <= 1'b0;
            end else if (en) begin
                vld_reg[g+1] <= vld_reg[g];
            end
            if (en) begin
                rem_reg[g+1]  <= rem_next;
                q_reg[g+1]    <= {q_reg[g][NUM_W-2:0], qb};
                den_reg[g+1]  <= den_reg[g];
                neg_reg[g+1]  <= neg_reg[g];
                side_reg[g+1] <= side_reg[g];
            end
        end
    end

    // Clip to the signed output range
    logic [NUM_W-1:0] q;
    logic [NUM_W-1:0] lim;
    logic [OUT_W-1:0] mag;
    always_comb begin
        q   = q_reg[NUM_W];
        lim = neg_reg[NUM_W] ? (NUM_W'(1) << (OUT_W - 1))
                             : ((NUM_W'(1) << (OUT_W - 1)) - NUM_W'(1));
        out_sat = (q > lim);
        mag     = out_sat ? lim[OUT_W-1:0] : q[OUT_W-1:0];
        out_quot = neg_reg[NUM_W] ? (OUT_W'(0) - mag) : mag;
    end

    assign out_valid = vld_reg[NUM_W];
    assign out_side  = side_reg[NUM_W];
endmodule

@@ hw/rtl/qrs_disc.sv @@
// Discriminant stage: magnitudes, products, |b^2-4ac| and its sign.
// Depends on qrs_pkg.
module qrs_disc
    import qrs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [DATA_WIDTH-1:0]   coef_a,
    input  logic [DATA_WIDTH-1:0]   coef_b,
    input  logic [DATA_WIDTH-1:0]   coef_c,
    output logic                    out_valid,
    output logic [2*DATA_WIDTH+2:0] out_dmag,
    output logic                    out_dneg,
    output logic [DATA_WIDTH-1:0]   out_amag,
    output logic                    out_aneg,
    output logic [DATA_WIDTH:0]     out_negb
);
    localparam int W = DATA_WIDTH;
    localparam int PW = 2 * W + 3;

    // Stage 1: split into sign and magnitude
    logic         v1_reg;
    logic [W-1:0] am_reg, bm_reg, cm_reg;
    logic         an_reg, bn_reg, cn_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
        end
        if (en) begin
            an_reg <= coef_a[W-1];
            bn_reg <= coef_b[W-1];
            cn_reg <= coef_c[W-1];
            am_reg <= coef_a[W-1] ? W'(0) - coef_a : coef_a;
            bm_reg <= coef_b[W-1] ? W'(0) - coef_b : coef_b;
            cm_reg <= coef_c[W-1] ? W'(0) - coef_c : coef_c;
        end
    end

    // Stage 2: products (most-negative magnitude wraps to 2^(W-1) correctly)
    logic          v2_reg;
    logic [2*W-1:0] b2_reg, ac_reg;
    logic [W-1:0]   am2_reg;
    logic           an2_reg, bn2_reg, add_reg;
    logic [W-1:0]   bm2_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
        if (en) begin
            b2_reg  <= (2*W)'(bm_reg) * (2*W)'(bm_reg);
            ac_reg  <= (2*W)'(am_reg) * (2*W)'(cm_reg);
            am2_reg <= am_reg;
            an2_reg <= an_reg;
            bn2_reg <= bn_reg;
            bm2_reg <= bm_reg;
            add_reg <= (an_reg != cn_reg) || (cm_reg == '0);
        end
    end

    // Stage 3: combine into magnitude and sign of d
    logic [PW-1:0] b2w, ac4w, diff;
    always_comb begin
        b2w  = PW'(b2_reg);
        ac4w = PW'(ac_reg) << 2;
        diff = b2w - ac4w;
    end

    logic         v3_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
        if (en) begin
            if (add_reg) begin
                out_dmag <= b2w + ac4w;
                out_dneg <= 1'b0;
            end else if (!diff[PW-1]) begin
                out_dmag <= diff;
                out_dneg <= 1'b0;
            end else begin
                out_dmag <= ac4w - b2w;
                out_dneg <= 1'b1;
            end
            out_amag <= am2_reg;
            out_aneg <= an2_reg;
            out_negb <= bn2_reg ? {1'b0, bm2_reg} : ((W+1)'(0) - {1'b0, bm2_reg});
        end
    end
    assign out_valid = v3_reg;
endmodule

@@ hw/rtl/qrs_checker.sv @@
// Port-level checker for the quadratic root solver, bound to the top level.
// Depends on qrs_pkg.
module qrs_checker
    import qrs_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_ready,
    input logic                  m_valid,
    input logic                  m_ready,
    input logic [1:0]            m_root_kind,
    input logic [DATA_WIDTH-1:0] m_first_value,
    input logic [DATA_WIDTH-1:0] m_second_value,
    input logic                  m_saturated
);
    // Hold a stalled result word
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_first_value)
                                && $stable(m_second_value))
        else $error("result word changed while stalled");

    // a zero gives an all-zero word
    a_azero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_kind == KIND_A_ZERO |->
            m_first_value == '0 && m_second_value == '0 && !m_saturated)
        else $error("a-zero word not cleared");

    // Double root has no second value
    a_double: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_root_kind == KIND_DOUBLE |-> m_second_value == '0)
        else $error("double root carries a second value");

    // Input is taken whenever the output side is free
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
endmodule

bind quadratic_root_solver qrs_checker #(.DATA_WIDTH(DATA_WIDTH)) u_qrs_checker (
    .aclk(aclk), .aresetn(aresetn), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready), .m_root_kind(m_root_kind),
    .m_first_value(m_first_value), .m_second_value(m_second_value),
    .m_saturated(m_saturated)
);
